### rtl/core/dca_pkg.sv
// Shared constants and types of the DTW cost accumulator.
package dca_pkg;

	localparam int CostW      = 32;
	localparam int LocalW     = 24;
	localparam int CountW     = 11;
	localparam int IdxW       = 10;
	localparam int RowLimit   = 1024;
	localparam int DefMaxCols = 1024;
	localparam int QueueDepth = 2;
	localparam int DataW      = 32;
	localparam int AddrW      = 3;

	localparam logic [CostW-1:0] CostInf = {CostW{1'b1}};

	// register map, selected by paddr[2]
	typedef enum logic {
		REG_ROW_COUNT = 1'b0,
		REG_COL_COUNT = 1'b1
	} reg_idx_t;

	// one classified cell handed from front to back
	typedef struct packed {
		logic [LocalW-1:0] local_cost;
		logic [IdxW-1:0]   col;
		logic              row_start;
		logic              first_row;
		logic              last_cell;
	} cell_t;

endpackage

### rtl/core/dca_in_if.sv
// Input channel: one local distance per word.
interface dca_in_if;
	logic                         valid;
	logic                         ready;
	logic [dca_pkg::LocalW-1:0]   local_cost;

	modport source (output valid, output local_cost, input ready);
	modport sink   (input valid, input local_cost, output ready);
endinterface

### rtl/core/dca_out_if.sv
// Output channel: accumulated cost and final-cell flag per word.
interface dca_out_if;
	logic                        valid;
	logic                        ready;
	logic [dca_pkg::CostW-1:0]   acc_cost;
	logic                        last_cell;

	modport source (output valid, output acc_cost, output last_cell, input ready);
	modport sink   (input valid, input acc_cost, input last_cell, output ready);
endinterface

### rtl/core/dca_front.sv
// Front end: config registers, cell position counters, cell classification.
module dca_front #(
	parameter int MAX_COLS = dca_pkg::DefMaxCols
) (
	input  logic                        clk,
	input  logic                        arst_n,
	dca_in_if.sink                      cell_in,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dca_pkg::AddrW-1:0]   paddr,
	input  logic [dca_pkg::DataW-1:0]   pwdata,
	output logic [dca_pkg::DataW-1:0]   prdata,
	input  logic                        q_full,
	output logic                        push,
	output dca_pkg::cell_t              push_cell
);
	import dca_pkg::*;

	localparam logic [CountW-1:0] RowLim = CountW'(RowLimit);
	localparam logic [CountW-1:0] ColLim = CountW'((MAX_COLS < RowLimit) ? MAX_COLS : RowLimit);

	logic [IdxW-1:0]   row_last_q, col_last_q;
	logic [IdxW-1:0]   row_q, col_q;
	logic              cfg_wr;
	logic              row_end, col_end;
	logic [CountW-1:0] wr_val;
	logic [IdxW-1:0]   row_wr_last, col_wr_last;
	reg_idx_t          sel;

	assign cfg_wr  = psel && penable && pwrite;
	assign sel     = reg_idx_t'(paddr[2]);
	assign wr_val  = pwdata[CountW-1:0];

	// count of zero reads as one; above the limit reads as the limit
	always_comb begin
		row_wr_last = '0;
		col_wr_last = '0;
		if (wr_val == '0) begin
			row_wr_last = '0;
			col_wr_last = '0;
		end else begin
			row_wr_last = (wr_val > RowLim) ? IdxW'(RowLim - 1'b1) : IdxW'(wr_val - 1'b1);
			col_wr_last = (wr_val > ColLim) ? IdxW'(ColLim - 1'b1) : IdxW'(wr_val - 1'b1);
		end
	end

	always_comb begin
		prdata = '0;
		unique case (sel)
			REG_ROW_COUNT: prdata = DataW'({1'b0, row_last_q} + CountW'(1));
			REG_COL_COUNT: prdata = DataW'({1'b0, col_last_q} + CountW'(1));
			default:       prdata = '0;
		endcase
	end

	assign cell_in.ready = !q_full;
	assign push          = cell_in.valid && !q_full;
	assign row_end       = (row_q == row_last_q);
	assign col_end       = (col_q == col_last_q);

	always_comb begin
		push_cell.local_cost = cell_in.local_cost;
		push_cell.col        = col_q;
		push_cell.row_start  = (col_q == '0);
		push_cell.first_row  = (row_q == '0);
		push_cell.last_cell  = row_end && col_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_last_q <= '0;
			col_last_q <= '0;
			row_q      <= '0;
			col_q      <= '0;
		end else if (cfg_wr) begin
			// any register write restarts the matrix
			unique case (sel)
				REG_ROW_COUNT: row_last_q <= row_wr_last;
				REG_COL_COUNT: col_last_q <= col_wr_last;
				default: ;
			endcase
			row_q <= '0;
			col_q <= '0;
		end else if (push) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	a_restart_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_cell.last_cell |=> row_q == '0 && col_q == '0)
		else $error("position not restarted after final cell");

endmodule

### rtl/core/dca_queue.sv
// Short queue of classified cells between front and back.
module dca_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dca_pkg::cell_t  push_cell,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output dca_pkg::cell_t  head_cell
);
	import dca_pkg::*;

	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW = $clog2(QueueDepth + 1);

	cell_t           entry_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
		return (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (count_q == CntW'(QueueDepth));
	assign head_valid = (count_q != '0);
	assign head_cell  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cell;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(QueueDepth))
		else $error("queue holds more than its depth");

	a_no_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");

endmodule

### rtl/core/dca_back.sv
// Back end: row store, three-way min with saturating add, output register.
module dca_back #(
	parameter int MAX_COLS = dca_pkg::DefMaxCols
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  dca_pkg::cell_t  head_cell,
	output logic            pop,
	dca_out_if.source       cell_out
);
	import dca_pkg::*;

	localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	logic [CostW-1:0] row_mem [MAX_COLS];

	cell_t            cell_s2;
	logic             valid_s2;
	logic [CostW-1:0] rd_s2;
	logic             fwd_s2;
	logic [CostW-1:0] fwd_cost_s2;

	logic [CostW-1:0] left_q, diag_q;
	logic [CostW-1:0] acc_q;
	logic             last_q;
	logic             out_valid_q;

	logic             s2_adv;
	logic [AW-1:0]    head_addr, s2_addr;
	logic [CostW-1:0] up_raw, up, left, diag, best;
	logic [CostW:0]   sum;
	logic [CostW-1:0] cost;

	assign head_addr = AW'(head_cell.col);
	assign s2_addr   = AW'(cell_s2.col);
	assign s2_adv    = valid_s2 && (!out_valid_q || cell_out.ready);
	assign pop       = head_valid && (!valid_s2 || s2_adv);

	// one-column matrix: the cell above is being written on the same edge
	assign up_raw = fwd_s2 ? fwd_cost_s2 : rd_s2;

	always_comb begin
		up   = cell_s2.first_row ? CostInf : up_raw;
		left = cell_s2.row_start ? CostInf : left_q;
		if (cell_s2.row_start)
			diag = cell_s2.first_row ? '0 : CostInf;
		else
			diag = diag_q;
		best = up;
		if (diag < best) best = diag;
		if (left < best) best = left;
		sum  = {1'b0, best} + (CostW + 1)'(cell_s2.local_cost);
		cost = sum[CostW] ? CostInf : sum[CostW-1:0];
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			row_mem[s2_addr] <= cost;
		end
		if (pop) begin
			rd_s2 <= row_mem[head_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cell_s2     <= head_cell;
			fwd_s2      <= s2_adv && (s2_addr == head_addr);
			fwd_cost_s2 <= cost;
		end
		if (s2_adv) begin
			left_q <= cost;
			diag_q <= up;
			acc_q  <= cost;
			last_q <= cell_s2.last_cell;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop)         valid_s2 <= 1'b1;
			else if (s2_adv) valid_s2 <= 1'b0;
			if (s2_adv)                  out_valid_q <= 1'b1;
			else if (cell_out.ready)     out_valid_q <= 1'b0;
		end
	end

	assign cell_out.valid     = out_valid_q;
	assign cell_out.acc_cost  = acc_q;
	assign cell_out.last_cell = last_q;

	a_origin_cost: assert property (@(posedge clk) disable iff (!arst_n)
		s2_adv && cell_s2.first_row && cell_s2.row_start
		|=> acc_q == CostW'($past(cell_s2.local_cost)))
		else $error("origin cell cost differs from its local distance");

endmodule

### rtl/core/dtw_cost_accumulator_core.sv
// Top level of the DTW accumulated-cost matrix engine.
//
// Usage:
//  - cell_in carries one 24-bit local distance per word, row by row, one
//    word per matrix cell. cell_out returns the 32-bit accumulated cost of
//    that cell; last_cell marks the final cell of the matrix, whose cost is
//    the total. The next word after it starts a new matrix.
//  - All ones on acc_cost means infinite or saturated.
//  - row_count (paddr 0) and col_count (paddr 4) are for the user to set over
//    the APB port while the engine is empty; the block does not enforce it.
//    Any write restarts the matrix. Only pwdata[10:0] is used: zero is taken
//    as one, values above the limit as the limit (1024 rows, MAX_COLS or 1024 columns).
//  - A word accepted on cell_in passes through the queue, the cell stage and
//    the output register to cell_out. Throughput: one word per cycle while
//    cell_out is not stalled; the min-and-add feeds the left and diagonal costs back.
//  - The row store is one MAX_COLS x 32 memory, read and written once per
//    cycle; a one-column matrix takes the above cost from a bypass path.
//  - A stalled receiver fills the output register, then the cell stage and
//    the two-word queue; cell_in.ready then drops.
//  - Reset empties the pipeline, sets both counts to one and starts a new
//    matrix. The row store needs no clearing: the first row never reads it.
module dtw_cost_accumulator_core #(
	parameter int MAX_COLS = dca_pkg::DefMaxCols
) (
	input  logic                        clk,
	input  logic                        arst_n,
	dca_in_if.sink                      cell_in,
	dca_out_if.source                   cell_out,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dca_pkg::AddrW-1:0]   paddr,
	input  logic [dca_pkg::DataW-1:0]   pwdata,
	output logic [dca_pkg::DataW-1:0]   prdata,
	output logic                        pready
);
	import dca_pkg::*;

	logic  q_full, push, pop, head_valid;
	cell_t push_cell, head_cell;

	assign pready = 1'b1;

	// front: config and cell classification
	dca_front #(.MAX_COLS(MAX_COLS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cell_in   (cell_in),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.q_full    (q_full),
		.push      (push),
		.push_cell (push_cell)
	);

	// decouples input acceptance from output back-pressure
	dca_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cell  (push_cell),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cell  (head_cell)
	);

	// back: row store, cost update, output register
	dca_back #(.MAX_COLS(MAX_COLS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cell  (head_cell),
		.pop        (pop),
		.cell_out   (cell_out)
	);

endmodule
